FILE: design/twrdc_pkg.sv
`default_nettype none
package twrdc_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned TRAVEL_W = 31;
  localparam int unsigned LIMIT_W  = 31;
  localparam int unsigned WIDE_W   = TIME_W + 2;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(524289);

  // register index taken from the word address
  typedef enum logic [0:0] {
    REG_DURATION_LIMIT = 1'b0
  } reg_idx_e;

  typedef logic signed [TIME_W-1:0] time_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef struct packed {
    time_t                window_start;
    time_t                window_end;
    logic [TRAVEL_W-1:0]  travel_time;
    logic                 first_stop;
    logic                 last_stop;
  } stop_t;

  // clamp a wide exact sum to the signed 32-bit range
  function automatic time_t sat_time(wide_t v);
    time_t r;
    if (v[WIDE_W-1:TIME_W-1] == '0 || v[WIDE_W-1:TIME_W-1] == '1) begin
      r = v[TIME_W-1:0];
    end else if (v[WIDE_W-1]) begin
      r = {1'b1, {(TIME_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(TIME_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: design/twrdc_if.sv
`default_nettype none
interface twrdc_stop_if;
  import twrdc_pkg::*;

  logic                valid;
  logic                ready;
  time_t               window_start;
  time_t               window_end;
  logic [TRAVEL_W-1:0] travel_time;
  logic                first_stop;
  logic                last_stop;

  modport source (
    output valid, window_start, window_end, travel_time, first_stop, last_stop,
    input  ready
  );
  modport sink (
    input  valid, window_start, window_end, travel_time, first_stop, last_stop,
    output ready
  );
endinterface

interface twrdc_result_if;
  import twrdc_pkg::*;

  logic  valid;
  logic  ready;
  time_t total_duration;
  time_t total_time_warp;
  logic  within_limit;
  logic  route_done;

  modport source (
    output valid, total_duration, total_time_warp, within_limit, route_done,
    input  ready
  );
  modport sink (
    input  valid, total_duration, total_time_warp, within_limit, route_done,
    output ready
  );
endinterface
`default_nettype wire

FILE: design/time_window_route_duration_check.sv
// channel    dir  handshake      beat contents
// stop_i     in   valid/ready    window_start, window_end, travel_time, first_stop, last_stop
// result_o   out  valid/ready    total_duration, total_time_warp, within_limit, route_done
// apb        in   psel/penable   duration_limit at byte address 0
//
// one stop per cycle sustained while results are taken; each stop beat passes
// through the input register, then fold logic into the result register
// the summary registers update when a stop moves into the result register,
// so each stop sees the summary left by the one before it
// reset clears the summary to zero and the limit to about 8.00001
// a stalled result holds; the input register still takes one more stop behind it
`default_nettype none
module time_window_route_duration_check (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  twrdc_stop_if.sink                    stop_i,
  twrdc_result_if.source                result_o,
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire [twrdc_pkg::APB_AW-1:0]   paddr,
  input  wire [twrdc_pkg::APB_DW-1:0]   pwdata,
  output logic [twrdc_pkg::APB_DW-1:0]  prdata,
  output logic                          pready
);
  import twrdc_pkg::*;

  logic [LIMIT_W-1:0] limit_q;
  reg_idx_e           reg_idx;

  logic  stage_valid_q;
  stop_t stage_q;
  logic  out_valid_q;
  logic  advance;

  time_t run_earliest_q, run_earliest_d;
  time_t run_latest_q, run_latest_d;
  time_t run_warp_q, run_warp_d;
  time_t run_dur_q, run_dur_d;

  time_t dur_out_q, warp_out_q;
  logic  within_q, done_q;
  logic  within_d;

  time_t delta, dwait, dwarp;
  wide_t hi_w, lo_w;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[APB_AW-1]);

  always_comb begin
    case (reg_idx)
      REG_DURATION_LIMIT: prdata = APB_DW'(limit_q);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (psel && penable && pwrite && reg_idx == REG_DURATION_LIMIT) begin
      limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  // handshake
  assign advance      = stage_valid_q && (!out_valid_q || result_o.ready);
  assign stop_i.ready = !stage_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (stop_i.ready) begin
        stage_valid_q <= stop_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stop_i.valid && stop_i.ready) begin
      stage_q.window_start <= stop_i.window_start;
      stage_q.window_end   <= stop_i.window_end;
      stage_q.travel_time  <= stop_i.travel_time;
      stage_q.first_stop   <= stop_i.first_stop;
      stage_q.last_stop    <= stop_i.last_stop;
    end
  end

  // time-warp concatenation of the summary with a one-stop sequence; a first stop starts a new summary
  always_comb begin
    delta = sat_time(WIDE_W'(run_dur_q) - WIDE_W'(run_warp_q)
                     + $signed(WIDE_W'(stage_q.travel_time)));
    dwait = sat_time(WIDE_W'(stage_q.window_start) - WIDE_W'(delta)
                     - WIDE_W'(run_latest_q));
    if (dwait < 0) begin
      dwait = '0;
    end
    dwarp = sat_time(WIDE_W'(run_earliest_q) + WIDE_W'(delta)
                     - WIDE_W'(stage_q.window_end));
    if (dwarp < 0) begin
      dwarp = '0;
    end

    hi_w = WIDE_W'(stage_q.window_start) - WIDE_W'(delta);
    if (WIDE_W'(run_earliest_q) > hi_w) begin
      hi_w = WIDE_W'(run_earliest_q);
    end
    lo_w = WIDE_W'(stage_q.window_end) - WIDE_W'(delta);
    if (WIDE_W'(run_latest_q) < lo_w) begin
      lo_w = WIDE_W'(run_latest_q);
    end

    if (stage_q.first_stop) begin
      run_earliest_d = stage_q.window_start;
      run_latest_d   = stage_q.window_end;
      run_warp_d     = '0;
      run_dur_d      = '0;
    end else begin
      run_dur_d      = sat_time(WIDE_W'(run_dur_q) + WIDE_W'(dwait)
                                + $signed(WIDE_W'(stage_q.travel_time)));
      run_warp_d     = sat_time(WIDE_W'(run_warp_q) + WIDE_W'(dwarp));
      run_earliest_d = sat_time(hi_w - WIDE_W'(dwait));
      run_latest_d   = sat_time(lo_w + WIDE_W'(dwarp));
    end

    within_d = (WIDE_W'(run_dur_d) <= $signed(WIDE_W'(limit_q)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_earliest_q <= '0;
      run_latest_q   <= '0;
      run_warp_q     <= '0;
      run_dur_q      <= '0;
    end else if (advance) begin
      run_earliest_q <= run_earliest_d;
      run_latest_q   <= run_latest_d;
      run_warp_q     <= run_warp_d;
      run_dur_q      <= run_dur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      dur_out_q  <= run_dur_d;
      warp_out_q <= run_warp_d;
      within_q   <= within_d;
      done_q     <= stage_q.last_stop;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.total_duration  = dur_out_q;
  assign result_o.total_time_warp = warp_out_q;
  assign result_o.within_limit    = within_q;
  assign result_o.route_done      = done_q;

  a_input_free_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stage_valid_q |-> stop_i.ready)
    else $error("input register empty but stop not accepted");

  a_advance_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q && run_dur_q == dur_out_q && run_warp_q == warp_out_q)
    else $error("result register does not match summary after a fold");

  a_first_stop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && stage_q.first_stop |=> run_dur_q == '0 && run_warp_q == '0)
    else $error("first stop did not clear duration and warp");

  a_warp_never_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !stage_q.first_stop |=> run_warp_q >= $past(run_warp_q))
    else $error("time warp decreased inside a route");

  a_summary_holds_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(run_dur_q) && $stable(run_warp_q))
    else $error("summary changed without a fold");

endmodule
`default_nettype wire

FILE: bench/time_window_route_duration_check_tb.sv
`timescale 1ns / 1ps
module time_window_route_duration_check_tb;
  import twrdc_pkg::*;

  localparam longint Q_HI = 64'sd2147483647;
  localparam longint Q_LO = -64'sd2147483648;
  localparam longint TRAVEL_MAX = 64'sd2147483647;
  localparam longint ONE = 64'sd65536;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    time_t duration;
    time_t warp;
    logic  in_limit;
    logic  done;
  } route_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  twrdc_stop_if   stop_if ();
  twrdc_result_if result_if ();

  time_window_route_duration_check i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .stop_i   (stop_if),
    .result_o (result_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk_i = ~clk_i;

  // running sequence summary kept alongside the block
  longint sum_earliest = 0;
  longint sum_latest   = 0;
  longint sum_warp     = 0;
  longint sum_duration = 0;
  longint limit_q      = 64'sd524289;

  route_result_t pending_q[$];
  int unsigned errors = 0;
  int unsigned stops_sent = 0;
  int unsigned results_seen = 0;
  int unsigned routes_sent = 0;
  int unsigned noise_sent = 0;
  int unsigned limits_set = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 16;
  int unsigned recv_idle_pct = 72;

  function automatic longint clamp_q(longint v);
    if (v > Q_HI) return Q_HI;
    if (v < Q_LO) return Q_LO;
    return v;
  endfunction

  function automatic longint max_of(longint a, longint b);
    return (a > b) ? a : b;
  endfunction

  function automatic stop_t mk_stop(longint ws, longint we, longint t, bit first, bit last);
    stop_t s;
    s.window_start = time_t'(ws);
    s.window_end   = time_t'(we);
    s.travel_time  = t[TRAVEL_W-1:0];
    s.first_stop   = first;
    s.last_stop    = last;
    return s;
  endfunction

  // time-warp concatenation of one stop onto the running summary; a first stop starts a new one
  function automatic route_result_t fold_stop(stop_t s);
    route_result_t r;
    longint ws, we, t, delta, dwait, dwarp, hi, lo;
    ws = longint'(s.window_start);
    we = longint'(s.window_end);
    t  = longint'({1'b0, s.travel_time});
    if (s.first_stop) begin
      sum_earliest = ws;
      sum_latest   = we;
      sum_warp     = 0;
      sum_duration = 0;
    end else begin
      delta = clamp_q(sum_duration - sum_warp + t);
      dwait = max_of(clamp_q(ws - delta - sum_latest), 0);
      dwarp = max_of(clamp_q(sum_earliest + delta - we), 0);
      hi = max_of(ws - delta, sum_earliest);
      lo = we - delta;
      if (sum_latest < lo) lo = sum_latest;
      sum_duration = clamp_q(sum_duration + dwait + t);
      sum_warp     = clamp_q(sum_warp + dwarp);
      sum_earliest = clamp_q(hi - dwait);
      sum_latest   = clamp_q(lo + dwarp);
    end
    r.duration = time_t'(sum_duration);
    r.warp     = time_t'(sum_warp);
    r.in_limit = (sum_duration <= limit_q);
    r.done     = s.last_stop;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  // drive one stop beat, with a random gap in front of it
  task automatic send_stop(stop_t s);
    if ($urandom_range(99) < send_idle_pct) begin
      stop_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    stop_if.valid        <= 1'b1;
    stop_if.window_start <= s.window_start;
    stop_if.window_end   <= s.window_end;
    stop_if.travel_time  <= s.travel_time;
    stop_if.first_stop   <= s.first_stop;
    stop_if.last_stop    <= s.last_stop;
    do @(posedge clk_i); while (!stop_if.ready);
    pending_q.insert(pending_q.size(), fold_stop(s));
    stops_sent++;
  endtask

  // drop valid and wait until every result has come back
  task automatic drain();
    stop_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_duration_limit(longint value);
    logic [APB_DW-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_DURATION_LIMIT, 2'b00};
    pwdata  <= APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    limit_q = value & 64'h7fff_ffff;
    limits_set++;
    // read back, psel stays high into the read setup
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (longint'(got) != limit_q)
      report_mismatch("duration_limit readback", longint'(got), limit_q);
  endtask

  task automatic test_unrouted_start();
    // no first stop yet: joins the zero summary left by reset
    send_stop(mk_stop(10 * ONE, 20 * ONE, 3 * ONE, 1'b0, 1'b0));
    send_stop(mk_stop(-5 * ONE, -ONE, 0, 1'b0, 1'b1));
  endtask

  task automatic test_window_cases();
    send_stop(mk_stop(0, 100 * ONE, 0, 1'b1, 1'b0));
    send_stop(mk_stop(5 * ONE, 2 * ONE, ONE, 1'b0, 1'b0));
    send_stop(mk_stop(200 * ONE, 300 * ONE, 2 * ONE, 1'b0, 1'b1));
    send_stop(mk_stop(Q_LO, Q_HI, TRAVEL_MAX, 1'b1, 1'b1));
  endtask

  task automatic test_saturation();
    send_stop(mk_stop(Q_HI, Q_LO, 0, 1'b1, 1'b0));
    send_stop(mk_stop(Q_HI, Q_LO, TRAVEL_MAX, 1'b0, 1'b0));
    send_stop(mk_stop(Q_LO, Q_LO, TRAVEL_MAX, 1'b0, 1'b0));
    send_stop(mk_stop(Q_HI, Q_HI, TRAVEL_MAX, 1'b0, 1'b0));
    send_stop(mk_stop(Q_LO, Q_HI, 0, 1'b0, 1'b1));
    send_stop(mk_stop(Q_LO, Q_LO, TRAVEL_MAX, 1'b1, 1'b0));
    send_stop(mk_stop(Q_HI, Q_HI, TRAVEL_MAX, 1'b0, 1'b1));
  endtask

  task automatic test_limit_edges();
    // duration lands exactly on the reset limit, then one past it
    send_stop(mk_stop(0, 0, 0, 1'b1, 1'b0));
    send_stop(mk_stop(64'sd524289, 64'sd524289, 0, 1'b0, 1'b0));
    send_stop(mk_stop(0, Q_HI, 1, 1'b0, 1'b1));
    drain();
    set_duration_limit(0);
    send_stop(mk_stop(3 * ONE, 3 * ONE, 0, 1'b1, 1'b0));
    send_stop(mk_stop(0, Q_HI, 1, 1'b0, 1'b1));
    drain();
    set_duration_limit(Q_HI);
    send_stop(mk_stop(Q_HI, Q_HI, TRAVEL_MAX, 1'b0, 1'b1));
    drain();
  endtask

  task automatic send_route();
    int unsigned len, pick, span, step;
    longint arrive, ws, we, t;
    bit no_head, no_tail;
    pick = $urandom_range(99);
    if (pick < 70) span = 32'd64 << 16;
    else if (pick < 85) span = 32'd16384 << 16;
    else span = 32'h7fff_ffff;
    step = span >> 3;
    len = $urandom_range(1, 8);
    no_head = ($urandom_range(99) < 8);
    no_tail = ($urandom_range(99) < 8);
    arrive = longint'($urandom_range(span)) - longint'(span >> 1);
    for (int i = 0; i < len; i++) begin
      t = $urandom_range(step);
      arrive += t;
      ws = clamp_q(arrive + longint'($urandom_range(step)) - longint'(step >> 1));
      // mostly open windows, sometimes an empty one
      we = clamp_q(ws + longint'($urandom_range(span >> 2)) - longint'(span >> 4));
      send_stop(mk_stop(ws, we, t, (i == 0) && !no_head, (i == len - 1) && !no_tail));
    end
    routes_sent++;
  endtask

  task automatic send_noise();
    stop_t s;
    s.window_start = $urandom;
    s.window_end   = $urandom;
    s.travel_time  = TRAVEL_W'($urandom);
    s.first_stop   = 1'($urandom_range(1));
    s.last_stop    = 1'($urandom_range(1));
    send_stop(s);
    noise_sent++;
  endtask

  task automatic test_random_routes(int unsigned n_stops, longint limit);
    int unsigned target;
    set_duration_limit(limit);
    target = stops_sent + n_stops;
    while (stops_sent < target) begin
      if ($urandom_range(99) < 85) send_route();
      else send_noise();
    end
    drain();
  endtask

  initial begin
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    stop_if.valid = 1'b0;
    stop_if.window_start = '0;
    stop_if.window_end   = '0;
    stop_if.travel_time  = '0;
    stop_if.first_stop   = 1'b0;
    stop_if.last_stop    = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unrouted_start();
    test_window_cases();
    test_saturation();
    test_limit_edges();

    send_idle_pct = 16;
    recv_idle_pct = 72;
    test_random_routes(510, longint'($urandom_range(32'd16 << 16, 32'd300 << 16)));
    send_idle_pct = 72;
    recv_idle_pct = 16;
    test_random_routes(510, longint'($urandom_range(32'd8 << 16, 32'd120 << 16)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_routes(510, longint'($urandom_range(32'h7fff_ffff)));

    $display("checked %0d results from %0d stops: %0d routes, %0d noise beats",
             results_seen, stops_sent, routes_sent, noise_sent);
    $display("duration limit set %0d times, zero and full scale included", limits_set);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) result_if.ready <= 1'b0;
    else result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin : check_result
    route_result_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        $display("result beat with nothing expected");
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (result_if.total_duration !== want.duration)
          report_mismatch("total_duration", result_if.total_duration, want.duration);
        if (result_if.total_time_warp !== want.warp)
          report_mismatch("total_time_warp", result_if.total_time_warp, want.warp);
        if (result_if.within_limit !== want.in_limit)
          report_mismatch("within_limit", result_if.within_limit, want.in_limit);
        if (result_if.route_done !== want.done)
          report_mismatch("route_done", result_if.route_done, want.done);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending_q.size());
      $display("status: fail");
      $finish;
    end
  end

endmodule
